>>> design/assert_macros.svh
// Assertion macros shared by the RTL that carries checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// generic form: clock, active-low reset, property, message
`define ASSERT_CLKRST(lbl, ck, rn, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);

// house default: clk / arst_n
`define ASSERT_STD(lbl, prop, msg) \
	`ASSERT_CLKRST(lbl, clk, arst_n, prop, msg)

`endif

>>> design/tmp_pkg.sv
// Types and constants for the trapezoidal motion profile block
`timescale 1ns / 1ps
`default_nettype none
package tmp_pkg;

	localparam int NUM_W          = 84;  // dividend / product width
	localparam int DEN_W          = 48;  // divisor / multiplier width
	localparam int MUL_STEPS      = 40;  // multiplier bits consumed
	localparam int MAX_POINTS_DEF = 64;
	localparam int CFG_IDX_W      = 2;
	localparam int CFG_DATA_W     = 18;

	localparam logic [CFG_IDX_W-1:0] CFG_SMOOTHNESS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CYCLE_TIME = 2'd1;

	typedef enum logic {ALU_MUL, ALU_DIV} alu_op_t;

	typedef struct packed {
		logic               start;
		alu_op_t            op;
		logic [NUM_W-1:0]   a;
		logic [DEN_W-1:0]   b;
	} alu_req_t;

	typedef struct packed {
		logic               done;
		logic [NUM_W-1:0]   result;
		logic [DEN_W-1:0]   remainder;
	} alu_rsp_t;

	typedef struct packed {
		logic        [31:0] start_time;
		logic        [31:0] stop_time;
		logic signed [23:0] start_position;
		logic signed [23:0] stop_position;
	} seg_word_t;

	typedef struct packed {
		logic        [39:0] point_time;
		logic signed [23:0] position;
		logic signed [31:0] velocity;
		logic               last;
		logic               truncated;
	} pt_word_t;

endpackage
`default_nettype wire

>>> design/tmp_alu.sv
// Shared iterative unit: shift-add multiply and restoring divide, one bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module tmp_alu
	import tmp_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire alu_req_t req,
	output alu_rsp_t      rsp
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic             busy_q;
	logic             done_q;
	alu_op_t          op_q;
	logic [NUM_W-1:0] acc_q;   // product, or dividend shifting into quotient
	logic [NUM_W-1:0] mc_q;    // multiplicand
	logic [DEN_W-1:0] mp_q;    // multiplier, or divisor
	logic [DEN_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;

	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;
	logic             ge;

	assign trial = {rem_q, acc_q[NUM_W-1]};
	assign diff  = trial - {1'b0, mp_q};
	assign ge    = trial >= {1'b0, mp_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				op_q   <= req.op;
				mp_q   <= req.b;
				rem_q  <= '0;
				if (req.op == ALU_MUL) begin
					acc_q <= '0;
					mc_q  <= req.a;
					cnt_q <= CNT_W'(MUL_STEPS);
				end else begin
					acc_q <= req.a;
					cnt_q <= CNT_W'(NUM_W);
				end
			end else if (busy_q) begin
				case (op_q)
					ALU_MUL: begin
						if (mp_q[0])
							acc_q <= acc_q + mc_q;
						mc_q <= {mc_q[NUM_W-2:0], 1'b0};
						mp_q <= {1'b0, mp_q[DEN_W-1:1]};
					end
					ALU_DIV: begin
						rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
						acc_q <= {acc_q[NUM_W-2:0], ge};
					end
					default: ;
				endcase
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done      = done_q;
	assign rsp.result    = acc_q;
	assign rsp.remainder = rem_q;

endmodule
`default_nettype wire

>>> design/trapezoidal_motion_profile.sv
// Trapezoidal motion profile: segment in, sampled curve points out
// Sequencing: the first point word follows the a8 multiply and two divides (one when the
// segment has zero duration), then the work for the point; each further point takes two
// multiplies and two divides on the one shared unit; a phase change adds a pass through
// S_PT; linear points skip the unit. seg_stall is high from acceptance to the last point.
// arst_n clears the sequencer and restores smoothness 1.0 and cycle time 10 ms.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module trapezoidal_motion_profile
	import tmp_pkg::*;
#(
	parameter int MAX_POINTS = MAX_POINTS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  seg_valid,
	output logic                       seg_stall,
	input  wire seg_word_t             seg,
	output logic                       pt_valid,
	input  wire logic                  pt_stall,
	output pt_word_t                   pt,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int CNT_W = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;
	localparam logic [CNT_W-1:0] BUDGET = CNT_W'(MAX_POINTS - 1);

	typedef enum logic [3:0] {
		S_IDLE, S_A8, S_VX, S_CNT, S_PT, S_M1, S_D1, S_D2, S_M2, S_FIN, S_EMIT
	} state_t;

	typedef enum logic [1:0] {PH_ACC, PH_DEC, PH_STOP} phase_t;

	// configuration
	logic [17:0] smooth_q;
	logic [9:0]  cycle_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smooth_q <= 18'd65536;
			cycle_q  <= 10'd10;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_SMOOTHNESS: smooth_q <= cfg_data;
				CFG_CYCLE_TIME: cycle_q  <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	state_t             state_q;
	phase_t             phase_q;
	logic [31:0]        t0_q, tf_q, d_q;
	logic signed [23:0] g0_q, gf_q;
	logic [39:0]        a8_q;
	logic [43:0]        vx_mag_q;
	logic               vx_neg_q;
	logic [NUM_W-1:0]   qa_q;
	logic [NUM_W:0]     nd_q;
	logic               trunc_q;
	logic [CNT_W-1:0]   n_q, k_q;
	logic [40:0]        tau8_q, u8_q;
	logic [39:0]        x8_q;
	logic [39:0]        time_q;
	logic               last_q;
	logic [NUM_W-1:0]   qmag_q, velmag_q, pmag_q;
	logic               pt_valid_q;
	pt_word_t           pt_q;

	logic               alu_start_q;
	alu_op_t            alu_op_q;
	logic [NUM_W-1:0]   alu_a_q;
	logic [DEN_W-1:0]   alu_b_q;
	alu_req_t           alu_req;
	alu_rsp_t           alu_rsp;

	assign alu_req.start = alu_start_q;
	assign alu_req.op    = alu_op_q;
	assign alu_req.a     = alu_a_q;
	assign alu_req.b     = alu_b_q;

	tmp_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.rsp    (alu_rsp)
	);

	// smoothness magnitude clamped to 1.0
	logic [18:0] smag19;
	logic [16:0] smag;
	assign smag19 = smooth_q[17] ? (19'd0 - {1'b1, smooth_q}) : {1'b0, smooth_q};
	assign smag   = (smag19 > 19'd65536) ? 17'd65536 : smag19[16:0];

	logic [17:0] c8;
	assign c8 = {((cycle_q == 10'd0) ? 10'd1 : cycle_q), 8'h00};

	logic [39:0]        a8_n, r8_n;
	logic signed [24:0] g_w;
	logic [24:0]        gmag;
	assign a8_n = alu_rsp.result[48:9];
	assign r8_n = {d_q, 8'h00} - a8_n;
	assign g_w  = 25'(gf_q) - 25'(g0_q);
	assign gmag = g_w[24] ? (25'd0 - g_w) : g_w;

	// point count from a8 / c8
	logic [NUM_W:0]   nd_n;
	logic [NUM_W+1:0] total_n;
	assign nd_n    = (a8_q == 40'd0) ? '0
		: ((NUM_W+1)'(alu_rsp.result) + (NUM_W+1)'(alu_rsp.remainder != '0));
	assign total_n = (NUM_W+2)'(alu_rsp.result) + (NUM_W+2)'(1) + (NUM_W+2)'(nd_n);

	// result formatting
	logic [58:0]        offmag;
	logic [NUM_W-1:0]   offsum;
	logic [25:0]        offc;
	logic signed [27:0] soff, base, pos28;
	logic [23:0]        pos_sat;
	logic [31:0]        vel_sat;
	assign offsum = pmag_q + NUM_W'(1 << 24);
	assign offmag = offsum[83:25];
	assign offc   = (offmag > 59'h3FF_FFFF) ? 26'h3FF_FFFF : offmag[25:0];
	assign soff   = vx_neg_q ? (28'd0 - {2'b00, offc}) : {2'b00, offc};
	assign base   = (phase_q == PH_ACC) ? 28'(g0_q) : 28'(gf_q);
	assign pos28  = (phase_q == PH_ACC) ? (base + soff) : (base - soff);
	assign pos_sat = (pos28 > 28'sd8388607) ? 24'h7F_FFFF
		: (pos28 < -28'sd8388608) ? 24'h80_0000 : pos28[23:0];
	always_comb begin
		if (vx_neg_q)
			vel_sat = (velmag_q > NUM_W'(64'd2147483648)) ? 32'h8000_0000
				: (32'd0 - velmag_q[31:0]);
		else
			vel_sat = (velmag_q > NUM_W'(64'd2147483647)) ? 32'h7FFF_FFFF
				: velmag_q[31:0];
	end

	logic [NUM_W-1:0] vx_lin;
	assign vx_lin = (NUM_W'(vx_mag_q) + NUM_W'(128)) >> 8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pt_valid_q  <= 1'b0;
			alu_start_q <= 1'b0;
		end else begin
			alu_start_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (seg_valid) begin
						t0_q <= seg.start_time;
						tf_q <= seg.stop_time;
						d_q  <= seg.stop_time - seg.start_time;
						g0_q <= seg.start_position;
						gf_q <= seg.stop_position;
						if (seg.start_time <= seg.stop_time) begin
							alu_op_q    <= ALU_MUL;
							alu_a_q     <= NUM_W'(smag);
							alu_b_q     <= DEN_W'(seg.stop_time - seg.start_time);
							alu_start_q <= 1'b1;
							state_q     <= S_A8;
						end
					end
				end
				S_A8: begin
					if (alu_rsp.done) begin
						a8_q <= a8_n;
						if (d_q == 32'd0) begin
							vx_mag_q    <= '0;
							vx_neg_q    <= 1'b0;
							alu_a_q     <= NUM_W'(a8_n);
							alu_b_q     <= DEN_W'(c8);
							state_q     <= S_CNT;
						end else begin
							alu_a_q <= NUM_W'({gmag, 24'h000000}) + NUM_W'(r8_n >> 1);
							alu_b_q <= DEN_W'(r8_n);
							state_q <= S_VX;
						end
						alu_op_q    <= ALU_DIV;
						alu_start_q <= 1'b1;
					end
				end
				S_VX: begin
					if (alu_rsp.done) begin
						vx_mag_q    <= alu_rsp.result[43:0];
						vx_neg_q    <= g_w[24];
						alu_op_q    <= ALU_DIV;
						alu_a_q     <= NUM_W'(a8_q);
						alu_b_q     <= DEN_W'(c8);
						alu_start_q <= 1'b1;
						state_q     <= S_CNT;
					end
				end
				S_CNT: begin
					if (alu_rsp.done) begin
						qa_q    <= alu_rsp.result;
						nd_q    <= nd_n;
						trunc_q <= total_n > (NUM_W+2)'(BUDGET);
						n_q     <= '0;
						k_q     <= '0;
						tau8_q  <= '0;
						phase_q <= PH_ACC;
						state_q <= S_PT;
					end
				end
				S_PT: begin
					// pick the next sample, or move on to the next phase
					if (phase_q == PH_ACC && !(n_q < BUDGET && NUM_W'(k_q) <= qa_q)) begin
						phase_q <= PH_DEC;
						k_q     <= '0;
						u8_q    <= {1'b0, a8_q};
					end else if (phase_q == PH_DEC
							&& !(n_q < BUDGET && (NUM_W+1)'(k_q) < nd_q)) begin
						phase_q <= PH_STOP;
					end else begin
						case (phase_q)
							PH_ACC: begin
								x8_q   <= tau8_q[39:0];
								time_q <= {t0_q, 8'h00} + tau8_q[39:0];
								last_q <= 1'b0;
							end
							PH_DEC: begin
								x8_q   <= u8_q[39:0];
								time_q <= {tf_q, 8'h00} - u8_q[39:0];
								last_q <= 1'b0;
							end
							default: begin
								x8_q   <= '0;
								time_q <= {tf_q, 8'h00};
								last_q <= 1'b1;
							end
						endcase
						if (a8_q == 40'd0) begin
							velmag_q <= vx_lin;
							pmag_q   <= '0;
							state_q  <= S_FIN;
						end else begin
							alu_op_q    <= ALU_MUL;
							alu_a_q     <= NUM_W'(vx_mag_q);
							alu_b_q     <= (phase_q == PH_ACC) ? DEN_W'(tau8_q[39:0])
								: (phase_q == PH_DEC) ? DEN_W'(u8_q[39:0]) : '0;
							alu_start_q <= 1'b1;
							state_q     <= S_M1;
						end
					end
				end
				S_M1: begin
					if (alu_rsp.done) begin
						qmag_q      <= alu_rsp.result;
						alu_op_q    <= ALU_DIV;
						alu_a_q     <= alu_rsp.result + NUM_W'({a8_q, 7'h00});
						alu_b_q     <= DEN_W'({a8_q, 8'h00});
						alu_start_q <= 1'b1;
						state_q     <= S_D1;
					end
				end
				S_D1: begin
					if (alu_rsp.done) begin
						velmag_q    <= alu_rsp.result;
						alu_op_q    <= ALU_DIV;
						alu_a_q     <= qmag_q + NUM_W'(a8_q >> 1);
						alu_b_q     <= DEN_W'(a8_q);
						alu_start_q <= 1'b1;
						state_q     <= S_D2;
					end
				end
				S_D2: begin
					if (alu_rsp.done) begin
						alu_op_q    <= ALU_MUL;
						alu_a_q     <= NUM_W'(alu_rsp.result[43:0]);
						alu_b_q     <= DEN_W'(x8_q);
						alu_start_q <= 1'b1;
						state_q     <= S_M2;
					end
				end
				S_M2: begin
					if (alu_rsp.done) begin
						pmag_q  <= alu_rsp.result;
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					pt_q.point_time <= time_q;
					pt_q.position   <= pos_sat;
					pt_q.velocity   <= vel_sat;
					pt_q.last       <= last_q;
					pt_q.truncated  <= trunc_q;
					pt_valid_q      <= 1'b1;
					state_q         <= S_EMIT;
				end
				S_EMIT: begin
					if (!pt_stall) begin
						pt_valid_q <= 1'b0;
						if (last_q) begin
							state_q <= S_IDLE;
						end else begin
							n_q     <= n_q + 1'b1;
							k_q     <= k_q + 1'b1;
							tau8_q  <= tau8_q + 41'(c8);
							u8_q    <= u8_q - 41'(c8);
							state_q <= S_PT;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign seg_stall = (state_q != S_IDLE);
	assign pt_valid  = pt_valid_q;
	assign pt        = pt_q;

	// a word is only offered while a segment is in flight
	`ASSERT_STD(a_no_pt_when_idle, !seg_stall |-> !pt_valid, "point word while idle")
	// the final word of a segment returns the block to idle
	`ASSERT_STD(a_last_frees, pt_valid && !pt_stall && pt.last |=> !seg_stall,
		"not idle after last word")
	// the shared unit only finishes while the sequencer waits on it
	`ASSERT_STD(a_alu_done_wait, alu_rsp.done |-> (state_q == S_A8 || state_q == S_VX
		|| state_q == S_CNT || state_q == S_M1 || state_q == S_D1 || state_q == S_D2
		|| state_q == S_M2), "unit done outside a wait state")

endmodule
`default_nettype wire
